// ===== rtl/sbs_pkg.sv =====
// Shared types and defaults for the sparse bitset store.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbs_pkg;

  localparam int DEF_WORD_BITS   = 64;
  localparam int DEF_MAX_CHUNKS  = 16;
  localparam int DEF_INDEX_WIDTH = 16;

  localparam int ELEM_TOTAL_W  = 11;
  localparam int CHUNK_TOTAL_W = 5;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_TEST   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOOK,
    CELL_SET,
    CELL_CLR,
    CELL_INSERT,
    CELL_DROP
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } sbs_state_e;

  // Per-cell match flags, and their reduction over the whole chain.
  typedef struct packed {
    logic eq;
    logic member;
    logic drop;
  } sbs_flags_t;

endpackage

`default_nettype wire

// ===== rtl/sbs_cell.sv =====
// One chunk cell: a rank, a bit word, and the match flags of the current lookup.
// Depends on sbs_pkg; trades rank and word with its neighbors on insert and drop.
`default_nettype none

module sbs_cell import sbs_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS,
  parameter int RANK_W    = 10,
  parameter int CNT_W     = 5,
  parameter int IDX       = 0
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cell_op_e             op_i,
  input  wire [RANK_W-1:0]     rank_i,
  input  wire [WORD_BITS-1:0]  mask_i,
  input  wire [CNT_W-1:0]      used_i,
  input  wire                  prev_lt_i,
  input  wire [RANK_W-1:0]     prev_rank_i,
  input  wire [WORD_BITS-1:0]  prev_bits_i,
  input  wire [RANK_W-1:0]     next_rank_i,
  input  wire [WORD_BITS-1:0]  next_bits_i,
  output logic [RANK_W-1:0]    rank_o,
  output logic [WORD_BITS-1:0] bits_o,
  output logic                 lt_o,
  output sbs_flags_t           flags_o
);

  logic [RANK_W-1:0]    rank_q;
  logic [WORD_BITS-1:0] bits_q;
  logic                 lt_q, eq_q, hitbit_q, nz_q;
  logic                 in_use;

  assign in_use = (used_i > CNT_W'(IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q     <= 1'b0;
      eq_q     <= 1'b0;
      hitbit_q <= 1'b0;
      nz_q     <= 1'b0;
    end else if (op_i == CELL_LOOK) begin
      lt_q     <= in_use && (rank_q < rank_i);
      eq_q     <= in_use && (rank_q == rank_i);
      hitbit_q <= |(bits_q & mask_i);
      nz_q     <= |(bits_q & ~mask_i);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_SET: begin
        if (eq_q) bits_q <= bits_q | mask_i;
      end
      CELL_CLR: begin
        if (eq_q) bits_q <= bits_q & ~mask_i;
      end
      CELL_INSERT: begin
        if (!lt_q) begin
          if (prev_lt_i) begin
            rank_q <= rank_i;
            bits_q <= mask_i;
          end else begin
            rank_q <= prev_rank_i;
            bits_q <= prev_bits_i;
          end
        end
      end
      CELL_DROP: begin
        if (!lt_q) begin
          rank_q <= next_rank_i;
          bits_q <= next_bits_i;
        end
      end
      default: ;
    endcase
  end

  assign rank_o         = rank_q;
  assign bits_o         = bits_q;
  assign lt_o           = lt_q;
  assign flags_o.eq     = eq_q;
  assign flags_o.member = eq_q && hitbit_q;
  assign flags_o.drop   = eq_q && hitbit_q && !nz_q;

endmodule

`default_nettype wire

// ===== rtl/sbs_chain.sv =====
// Row of chunk cells wired to their neighbors, with the match flags reduced.
// Depends on sbs_pkg and sbs_cell.
`default_nettype none

module sbs_chain import sbs_pkg::*; #(
  parameter int WORD_BITS  = DEF_WORD_BITS,
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
  parameter int RANK_W     = 10,
  parameter int CNT_W      = 5
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  cell_op_e            op_i,
  input  wire [RANK_W-1:0]    rank_i,
  input  wire [WORD_BITS-1:0] mask_i,
  input  wire [CNT_W-1:0]     used_i,
  output sbs_flags_t          sum_o
);

  logic [RANK_W-1:0]    rank_w  [MAX_CHUNKS];
  logic [WORD_BITS-1:0] bits_w  [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] lt_w;
  logic [MAX_CHUNKS-1:0] eq_w, member_w, drop_w;
  sbs_flags_t           flags_w [MAX_CHUNKS];

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_cell
    logic                 prev_lt;
    logic [RANK_W-1:0]    prev_rank, next_rank;
    logic [WORD_BITS-1:0] prev_bits, next_bits;

    if (i == 0) begin : g_first
      assign prev_lt   = 1'b1;
      assign prev_rank = '0;
      assign prev_bits = '0;
    end else begin : g_mid
      assign prev_lt   = lt_w[i-1];
      assign prev_rank = rank_w[i-1];
      assign prev_bits = bits_w[i-1];
    end

    if (i == MAX_CHUNKS - 1) begin : g_last
      assign next_rank = rank_w[i];
      assign next_bits = bits_w[i];
    end else begin : g_inner
      assign next_rank = rank_w[i+1];
      assign next_bits = bits_w[i+1];
    end

    sbs_cell #(
      .WORD_BITS (WORD_BITS),
      .RANK_W    (RANK_W),
      .CNT_W     (CNT_W),
      .IDX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op_i),
      .rank_i      (rank_i),
      .mask_i      (mask_i),
      .used_i      (used_i),
      .prev_lt_i   (prev_lt),
      .prev_rank_i (prev_rank),
      .prev_bits_i (prev_bits),
      .next_rank_i (next_rank),
      .next_bits_i (next_bits),
      .rank_o      (rank_w[i]),
      .bits_o      (bits_w[i]),
      .lt_o        (lt_w[i]),
      .flags_o     (flags_w[i])
    );

    assign eq_w[i]     = flags_w[i].eq;
    assign member_w[i] = flags_w[i].member;
    assign drop_w[i]   = flags_w[i].drop;
  end

  assign sum_o.eq     = |eq_w;
  assign sum_o.member = |member_w;
  assign sum_o.drop   = |drop_w;

endmodule

`default_nettype wire

// ===== rtl/sparse_bitset_store_unit.sv =====
// Sparse bitset store: a sorted row of rank/word chunk cells plus set counters.
// Depends on sbs_pkg and sbs_chain.
//
// Use: present req_type_i and elem_index_i with in_valid_i; the request is
// taken when in_ready_o is also high. Each request gives exactly one result
// beat on the output channel (was_member_o, store_full_o, element_total_o,
// chunk_total_o) under out_valid_o / out_ready_i.
// The rank comes from the index by a constant reciprocal multiply at
// accept. The next cycle every cell compares its rank in parallel while
// the bit position is taken as the remainder; then, once the output slot
// is free, the cells set or clear the bit, or shift one place toward or
// away from the neighbor to insert or drop a chunk. A new request is
// taken only in idle, after the accept/compare/update sequence finishes.
// Reset clears the chunk and element counts; the chunk cells need no sweep.
// While the receiver stalls, the finished beat holds in the output register
// and the next request waits in its update cycle until the slot frees.
`default_nettype none

module sparse_bitset_store_unit import sbs_pkg::*; #(
  parameter int WORD_BITS   = DEF_WORD_BITS,
  parameter int MAX_CHUNKS  = DEF_MAX_CHUNKS,
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire [1:0]               req_type_i,
  input  wire [INDEX_WIDTH-1:0]   elem_index_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic                    was_member_o,
  output logic                    store_full_o,
  output logic [ELEM_TOTAL_W-1:0] element_total_o,
  output logic [CHUNK_TOTAL_W-1:0] chunk_total_o
);

  localparam int POS_W   = $clog2(WORD_BITS);
  localparam int SHIFT   = INDEX_WIDTH + POS_W;
  localparam int RECIP_W = INDEX_WIDTH + 2;
  localparam int PROD_W  = INDEX_WIDTH + RECIP_W;
  localparam int RANK_W  =
    $clog2(int'(((64'd1 << INDEX_WIDTH) - 64'd1) / 64'(WORD_BITS)) + 1);
  localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
  localparam int ELEM_W  = $clog2(MAX_CHUNKS * WORD_BITS + 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
    ((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));
  localparam logic [INDEX_WIDTH-1:0] WORD_CONST = INDEX_WIDTH'(WORD_BITS);

  sbs_state_e             state_q, state_d;
  req_e                   req_q;
  logic [INDEX_WIDTH-1:0] idx_q;
  logic [RANK_W-1:0]      rank_q;
  logic [WORD_BITS-1:0]   mask_q, mask_d, mask_cell;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [ELEM_W-1:0]      elem_q, elem_d;
  logic                   out_valid_q, out_valid_d;
  logic                   member_q, full_q, member_d, full_d;
  logic [ELEM_TOTAL_W-1:0]  etot_q;
  logic [CHUNK_TOTAL_W-1:0] ctot_q;

  logic [PROD_W-1:0]      prod;
  logic [INDEX_WIDTH-1:0] base, diff;
  logic [POS_W-1:0]       pos;
  logic                   accept, slot_free, fire;
  cell_op_e               cell_op;
  sbs_flags_t             sum;

  assign prod   = PROD_W'(elem_index_i) * PROD_W'(RECIP);
  assign base   = INDEX_WIDTH'(INDEX_WIDTH'(rank_q) * WORD_CONST);
  assign diff   = idx_q - base;
  assign pos    = diff[POS_W-1:0];
  assign mask_d = WORD_BITS'(1) << pos;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = (state_q == ST_UPDATE) && slot_free;
  assign mask_cell = (state_q == ST_LOOK) ? mask_d : mask_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK:   state_d = ST_UPDATE;
      ST_UPDATE: if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cell_op    = (state_q == ST_LOOK) ? CELL_LOOK : CELL_HOLD;
    used_d     = used_q;
    elem_d     = elem_q;
    member_d   = sum.member;
    full_d     = 1'b0;
    if (fire) begin
      unique case (req_q)
        REQ_ADD: begin
          if (sum.eq) begin
            if (!sum.member) begin
              cell_op = CELL_SET;
              elem_d  = elem_q + ELEM_W'(1);
            end
          end else if (used_q == CNT_W'(MAX_CHUNKS)) begin
            full_d = 1'b1;
          end else begin
            cell_op = CELL_INSERT;
            used_d  = used_q + CNT_W'(1);
            elem_d  = elem_q + ELEM_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (sum.member) begin
            elem_d = elem_q - ELEM_W'(1);
            if (sum.drop) begin
              cell_op = CELL_DROP;
              used_d  = used_q - CNT_W'(1);
            end else begin
              cell_op = CELL_CLR;
            end
          end
        end
        REQ_CLEAR: begin
          member_d = 1'b0;
          used_d   = '0;
          elem_d   = '0;
        end
        default: ;
      endcase
    end
    out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  sbs_chain #(
    .WORD_BITS  (WORD_BITS),
    .MAX_CHUNKS (MAX_CHUNKS),
    .RANK_W     (RANK_W),
    .CNT_W      (CNT_W)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (cell_op),
    .rank_i (rank_q),
    .mask_i (mask_cell),
    .used_i (used_q),
    .sum_o  (sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      elem_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      elem_q      <= elem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_e'(req_type_i);
      idx_q  <= elem_index_i;
      rank_q <= prod[SHIFT +: RANK_W];
    end
    if (state_q == ST_LOOK) begin
      mask_q <= mask_d;
    end
    if (fire) begin
      member_q <= member_d;
      full_q   <= full_d;
      etot_q   <= ELEM_TOTAL_W'(elem_d);
      ctot_q   <= CHUNK_TOTAL_W'(used_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign was_member_o    = member_q;
  assign store_full_o    = full_q;
  assign element_total_o = etot_q;
  assign chunk_total_o   = ctot_q;

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_CHUNKS))
    else $error("chunk count above capacity");

  a_elem_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ELEM_W'(used_q) <= elem_q)
    else $error("more chunks than elements");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOK))
    else $error("accepted beat did not start lookup");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && out_valid_q && !out_ready_i)
      |=> (state_q == ST_UPDATE && $stable(used_q) && $stable(elem_q)))
    else $error("update applied while result slot busy");
`endif

endmodule

`default_nettype wire

// ===== verif/sbs_mirror_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the sparse bitset store: a shadow copy of the chunk list that
// predicts one reply beat per request and checks replies in order.
// Depends on sbs_pkg.

package sbs_mirror_pkg;
  import sbs_pkg::*;

  localparam int CHUNKS = DEF_MAX_CHUNKS;
  localparam int POS_W  = $clog2(DEF_WORD_BITS);
  localparam int RANK_W = DEF_INDEX_WIDTH - POS_W;

  typedef struct packed {
    logic                     was_member;
    logic                     store_full;
    logic [ELEM_TOTAL_W-1:0]  element_total;
    logic [CHUNK_TOTAL_W-1:0] chunk_total;
  } set_reply_t;

  class bitset_mirror;
    logic [RANK_W-1:0]        rank_tab [CHUNKS];
    logic [DEF_WORD_BITS-1:0] word_tab [CHUNKS];
    int                       chunks_live;
    int                       elems_live;
    set_reply_t               replies_due [$];
    int unsigned              errors;

    function new();
      chunks_live = 0;
      elems_live  = 0;
      errors      = 0;
    endfunction

    function void take_request(req_e op, logic [DEF_INDEX_WIDTH-1:0] idx);
      logic [RANK_W-1:0] rank;
      logic [POS_W-1:0]  pos;
      int                slot;
      int                k;
      bit                hit;
      bit                member;
      bit                full;
      set_reply_t        reply;
      rank = idx[DEF_INDEX_WIDTH-1:POS_W];
      pos  = idx[POS_W-1:0];
      slot = 0;
      while (slot < chunks_live && rank_tab[slot] < rank) slot++;
      hit    = (slot < chunks_live) && (rank_tab[slot] == rank);
      member = hit && word_tab[slot][pos];
      full   = 1'b0;
      case (op)
        REQ_ADD: begin
          if (hit) begin
            if (!member) begin
              word_tab[slot][pos] = 1'b1;
              elems_live++;
            end
          end else if (chunks_live >= CHUNKS) begin
            full = 1'b1;
          end else begin
            for (k = chunks_live; k > slot; k--) begin
              rank_tab[k] = rank_tab[k-1];
              word_tab[k] = word_tab[k-1];
            end
            rank_tab[slot]      = rank;
            word_tab[slot]      = '0;
            word_tab[slot][pos] = 1'b1;
            chunks_live++;
            elems_live++;
          end
        end
        REQ_REMOVE: begin
          if (member) begin
            word_tab[slot][pos] = 1'b0;
            elems_live--;
            if (word_tab[slot] == '0) begin
              for (k = slot; k + 1 < chunks_live; k++) begin
                rank_tab[k] = rank_tab[k+1];
                word_tab[k] = word_tab[k+1];
              end
              chunks_live--;
            end
          end
        end
        REQ_CLEAR: begin
          member      = 1'b0;
          chunks_live = 0;
          elems_live  = 0;
        end
        default: ;
      endcase
      reply.was_member    = member;
      reply.store_full    = full;
      reply.element_total = elems_live[ELEM_TOTAL_W-1:0];
      reply.chunk_total   = chunks_live[CHUNK_TOTAL_W-1:0];
      replies_due = {replies_due, reply};
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task match_reply(set_reply_t got);
      set_reply_t want;
      if (replies_due.size() == 0) begin
        report("reply beat with no request outstanding");
      end else begin
        want = replies_due.pop_front();
        if (got.was_member !== want.was_member)
          report($sformatf("was_member %b, want %b", got.was_member, want.was_member));
        if (got.store_full !== want.store_full)
          report($sformatf("store_full %b, want %b", got.store_full, want.store_full));
        if (got.element_total !== want.element_total)
          report($sformatf("element_total %0d, want %0d",
                           got.element_total, want.element_total));
        if (got.chunk_total !== want.chunk_total)
          report($sformatf("chunk_total %0d, want %0d", got.chunk_total, want.chunk_total));
      end
    endtask
  endclass

endpackage

// ===== verif/tb_sparse_bitset_store_unit.sv =====
`timescale 1ns / 100ps
// Testbench for sparse_bitset_store_unit: directed and random add/test/remove/clear
// beats with random gaps and stalls, checked against bitset_mirror.
// Depends on sbs_pkg, sbs_mirror_pkg and the RTL.

module tb_sparse_bitset_store_unit;
  import sbs_pkg::*;
  import sbs_mirror_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1050;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 req_type_i = 2'd0;
  logic [DEF_INDEX_WIDTH-1:0] elem_index_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b1;
  logic                       was_member_o;
  logic                       store_full_o;
  logic [ELEM_TOTAL_W-1:0]    element_total_o;
  logic [CHUNK_TOTAL_W-1:0]   chunk_total_o;

  bitset_mirror               mirror = new();
  logic [DEF_INDEX_WIDTH-1:0] added_q [$];
  logic                       rx_jitter = 1'b0;
  int                         rx_hold = 0;
  int                         quiet = 0;

  sparse_bitset_store_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .elem_index_i   (elem_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .was_member_o   (was_member_o),
    .store_full_o   (store_full_o),
    .element_total_o(element_total_o),
    .chunk_total_o  (chunk_total_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      mirror.match_reply({was_member_o, store_full_o, element_total_o, chunk_total_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("sparse_bitset_store_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int roll;
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!rx_jitter) begin
      out_ready_i <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready_i <= 1'b1;
        rx_hold     <= $urandom_range(0, 20);
      end else if (roll < 90) begin
        out_ready_i <= 1'b0;
        rx_hold     <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        rx_hold     <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int next_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(req_e op, logic [DEF_INDEX_WIDTH-1:0] idx, int gap);
    in_valid_i   <= 1'b1;
    req_type_i   <= op;
    elem_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mirror.take_request(op, idx);
    if (op == REQ_ADD) begin
      added_q = {added_q, idx};
      if (added_q.size() > 64) void'(added_q.pop_front());
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (mirror.replies_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int                   sent;
    int                   seg_len;
    int                   pool_n;
    int                   roll;
    bit                   calm;
    logic [RANK_W-1:0]    pool [24];
    logic [DEF_INDEX_WIDTH-1:0] idx;
    req_e                 op;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(REQ_ADD,    16'h0000, next_gap(0));
    send_request(REQ_ADD,    16'hFFFF, next_gap(0));
    send_request(REQ_TEST,   16'h0000, next_gap(0));
    send_request(REQ_TEST,   16'hFFFF, next_gap(0));
    send_request(REQ_ADD,    16'h0000, next_gap(0));
    send_request(REQ_REMOVE, 16'h0040, next_gap(0));
    send_request(REQ_TEST,   16'h0001, next_gap(0));
    send_request(REQ_REMOVE, 16'hFFFF, next_gap(0));
    for (int r = 1; r < CHUNKS; r++)
      send_request(REQ_ADD, {RANK_W'(r), POS_W'($urandom_range(0, 63))}, next_gap(0));
    send_request(REQ_ADD,   {RANK_W'(20), POS_W'(0)}, next_gap(0));
    send_request(REQ_ADD,   {RANK_W'(0), POS_W'(5)}, next_gap(0));
    send_request(REQ_CLEAR, 16'h5A5A, 0);
    drain_replies();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(40, 120);
      roll = $urandom_range(0, 99);
      if (roll < 30) pool_n = $urandom_range(1, 4);
      else if (roll < 80) pool_n = $urandom_range(8, 20);
      else pool_n = 24;
      for (int i = 0; i < pool_n; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) pool[i] = '0;
        else if (roll < 16) pool[i] = '1;
        else pool[i] = RANK_W'($urandom_range(0, (1 << RANK_W) - 1));
      end
      calm = ($urandom_range(0, 99) < 30);
      rx_jitter <= ($urandom_range(0, 99) >= 30);
      for (int n = 0; n < seg_len && sent < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 48) op = REQ_ADD;
        else if (roll < 66) op = REQ_TEST;
        else if (roll < 97) op = REQ_REMOVE;
        else op = REQ_CLEAR;
        idx = {pool[$urandom_range(0, pool_n - 1)], POS_W'($urandom_range(0, 63))};
        if (op != REQ_ADD && added_q.size() > 0 && $urandom_range(0, 1))
          idx = added_q[$urandom_range(0, added_q.size() - 1)];
        send_request(op, idx, next_gap(calm));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) drain_replies();
    end

    drain_replies();
    repeat (8) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.replies_due.size() == 0) begin
      $display("sparse_bitset_store_unit regression: pass");
    end else begin
      $display("sparse_bitset_store_unit regression: fail");
    end
    $finish;
  end

endmodule
